>>> hdl/ebca_pkg.sv
// ----------------------------------------------------------------------------
// ebca_pkg
// shared types, register map and defaults of the encoder/button code adjuster
// ----------------------------------------------------------------------------
package ebca_pkg;

  // design parameter defaults
  localparam int CODE_WIDTH_DEFAULT = 16;
  localparam int TIME_WIDTH_DEFAULT = 32;

  // apb port widths
  localparam int APB_ADDR_WIDTH = 5;
  localparam int APB_DATA_WIDTH = 32;

  // register indexes (byte address is index * 4)
  localparam logic [2:0] REG_DEBOUNCE_MS   = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS_MS = 3'd1;
  localparam logic [2:0] REG_DETENT_TICKS  = 3'd2;
  localparam logic [2:0] REG_FINE_STEP     = 3'd3;
  localparam logic [2:0] REG_COARSE_STEP   = 3'd4;

  // register reset values
  localparam logic [15:0] DEBOUNCE_MS_RESET   = 16'd80;
  localparam logic [15:0] LONG_PRESS_MS_RESET = 16'd600;
  localparam logic [7:0]  DETENT_TICKS_RESET  = 8'd4;
  localparam logic [15:0] FINE_STEP_RESET     = 16'd1;
  localparam logic [15:0] COARSE_STEP_RESET   = 16'd64;

  // request command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [7:0]  detent_ticks;
    logic [15:0] fine_step;
    logic [15:0] coarse_step;
  } ebca_cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        start_value;
    logic [1:0]         dac_channel;
    logic               button_level;
    logic signed [15:0] encoder_count;
    logic [31:0]        now_ms;
  } ebca_item_t;

  typedef struct packed {
    logic [15:0] dac_code;
    logic [1:0]  out_channel;
    logic        code_written;
    logic        coarse_mode;
    logic        confirmed;
    logic        session_active;
  } ebca_result_t;

endpackage

>>> hdl/ebca_if.sv
// ----------------------------------------------------------------------------
// ebca_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ebca_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [15:0]        start_value;
  logic [1:0]         dac_channel;
  logic               button_level;
  logic signed [15:0] encoder_count;
  logic [31:0]        now_ms;

  modport source (
    output valid, cmd, start_value, dac_channel, button_level, encoder_count, now_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, start_value, dac_channel, button_level, encoder_count, now_ms,
    output ready
  );
endinterface

interface ebca_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] dac_code;
  logic [1:0]  out_channel;
  logic        code_written;
  logic        coarse_mode;
  logic        confirmed;
  logic        session_active;

  modport source (
    output valid, dac_code, out_channel, code_written, coarse_mode, confirmed,
           session_active,
    input  ready
  );
  modport sink (
    input  valid, dac_code, out_channel, code_written, coarse_mode, confirmed,
           session_active,
    output ready
  );
endinterface

>>> hdl/ebca_regs.sv
// ----------------------------------------------------------------------------
// ebca_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module ebca_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ebca_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [ebca_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [ebca_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  output ebca_pkg::ebca_cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= ebca_pkg::DEBOUNCE_MS_RESET;
      cfg.long_press_ms <= ebca_pkg::LONG_PRESS_MS_RESET;
      cfg.detent_ticks  <= ebca_pkg::DETENT_TICKS_RESET;
      cfg.fine_step     <= ebca_pkg::FINE_STEP_RESET;
      cfg.coarse_step   <= ebca_pkg::COARSE_STEP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        ebca_pkg::REG_DEBOUNCE_MS:   cfg.debounce_ms   <= pwdata[15:0];
        ebca_pkg::REG_LONG_PRESS_MS: cfg.long_press_ms <= pwdata[15:0];
        ebca_pkg::REG_DETENT_TICKS:  cfg.detent_ticks  <= pwdata[7:0];
        ebca_pkg::REG_FINE_STEP:     cfg.fine_step     <= pwdata[15:0];
        ebca_pkg::REG_COARSE_STEP:   cfg.coarse_step   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ebca_pkg::REG_DEBOUNCE_MS:   prdata = 32'(cfg.debounce_ms);
      ebca_pkg::REG_LONG_PRESS_MS: prdata = 32'(cfg.long_press_ms);
      ebca_pkg::REG_DETENT_TICKS:  prdata = 32'(cfg.detent_ticks);
      ebca_pkg::REG_FINE_STEP:     prdata = 32'(cfg.fine_step);
      ebca_pkg::REG_COARSE_STEP:   prdata = 32'(cfg.coarse_step);
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> hdl/ebca_step.sv
// ----------------------------------------------------------------------------
// ebca_step
// session state and single-pass update for one request
// ----------------------------------------------------------------------------
module ebca_step #(
  parameter int CODE_WIDTH = ebca_pkg::CODE_WIDTH_DEFAULT,
  parameter int TIME_WIDTH = ebca_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  ebca_pkg::ebca_item_t    item,
  input  ebca_pkg::ebca_cfg_t     cfg,
  output ebca_pkg::ebca_result_t  res
);

  localparam int EW = CODE_WIDTH + 17;
  localparam logic [EW-1:0] CODE_MAX_EXT = {{17{1'b0}}, {CODE_WIDTH{1'b1}}};

  // state
  logic [CODE_WIDTH-1:0] code_value;
  logic [1:0]            channel_latch;
  logic [15:0]           encoder_reference;
  logic                  coarse_flag;
  logic                  swallow_flag;
  logic                  active_flag;
  logic                  stable_level;
  logic                  candidate_level;
  logic [TIME_WIDTH-1:0] candidate_since;
  logic                  edge_previous;
  logic                  hold_seen;
  logic [TIME_WIDTH-1:0] hold_start;
  logic                  hold_fired;

  logic [CODE_WIDTH-1:0] code_value_next;
  logic [1:0]            channel_latch_next;
  logic [15:0]           encoder_reference_next;
  logic                  coarse_flag_next;
  logic                  swallow_flag_next;
  logic                  active_flag_next;
  logic                  stable_level_next;
  logic                  candidate_level_next;
  logic [TIME_WIDTH-1:0] candidate_since_next;
  logic                  edge_previous_next;
  logic                  hold_seen_next;
  logic [TIME_WIDTH-1:0] hold_start_next;
  logic                  hold_fired_next;

  // datapath helpers
  logic [TIME_WIDTH-1:0] now_t;
  logic [7:0]            det;
  logic [15:0]           enc_diff;
  logic signed [16:0]    delta;
  logic signed [16:0]    det_pos;
  logic                  step_up;
  logic                  step_dn;
  logic [15:0]           inc;
  logic [EW-1:0]         code_ext;
  logic [EW-1:0]         inc_ext;
  logic [EW-1:0]         start_ext;
  logic [EW-1:0]         up_sum;
  logic [EW-1:0]         up_val;
  logic [EW-1:0]         dn_val;
  logic [EW-1:0]         start_val;
  logic                  press;
  logic                  fire;
  logic                  swallow_mid;
  logic                  written;
  logic                  confirm;
  logic [CODE_WIDTH+15:0] code_wide;

  assign now_t     = item.now_ms[TIME_WIDTH-1:0];
  assign det       = (cfg.detent_ticks == 8'd0) ? 8'd1 : cfg.detent_ticks;
  assign enc_diff  = item.encoder_count - encoder_reference;
  assign delta     = {enc_diff[15], enc_diff};
  assign det_pos   = {9'b0, det};
  assign step_up   = delta >= det_pos;
  assign step_dn   = delta <= -det_pos;
  assign inc       = coarse_flag ? cfg.coarse_step : cfg.fine_step;
  assign code_ext  = EW'(code_value);
  assign inc_ext   = EW'(inc);
  assign start_ext = EW'(item.start_value);
  assign up_sum    = code_ext + inc_ext;
  assign up_val    = (up_sum > CODE_MAX_EXT) ? CODE_MAX_EXT : up_sum;
  assign dn_val    = (inc_ext > code_ext) ? '0 : code_ext - inc_ext;
  assign start_val = (start_ext > CODE_MAX_EXT) ? CODE_MAX_EXT : start_ext;

  always_comb begin
    code_value_next        = code_value;
    channel_latch_next     = channel_latch;
    encoder_reference_next = encoder_reference;
    coarse_flag_next       = coarse_flag;
    swallow_flag_next      = swallow_flag;
    active_flag_next       = active_flag;
    stable_level_next      = stable_level;
    candidate_level_next   = candidate_level;
    candidate_since_next   = candidate_since;
    edge_previous_next     = edge_previous;
    hold_seen_next         = hold_seen;
    hold_start_next        = hold_start;
    hold_fired_next        = hold_fired;
    written                = 1'b0;
    confirm                = 1'b0;
    press                  = 1'b0;
    fire                   = 1'b0;
    swallow_mid            = swallow_flag;

    if (item.cmd == ebca_pkg::CMD_START || active_flag) begin
      // debouncer, one sample per request
      if (item.button_level != candidate_level) begin
        candidate_level_next = item.button_level;
        candidate_since_next = now_t;
      end else if (candidate_level != stable_level &&
                   (now_t - candidate_since) >= TIME_WIDTH'(cfg.debounce_ms)) begin
        stable_level_next = candidate_level;
      end

      // long-press tracker on the new debounced level
      if (stable_level_next && !hold_seen) begin
        hold_start_next = now_t;
        hold_fired_next = 1'b0;
      end
      if (!stable_level_next) begin
        hold_seen_next  = 1'b0;
        hold_fired_next = 1'b0;
      end else begin
        hold_seen_next = 1'b1;
        if (!hold_fired_next &&
            (now_t - hold_start_next) >= TIME_WIDTH'(cfg.long_press_ms)) begin
          hold_fired_next = 1'b1;
          fire            = 1'b1;
        end
      end
    end

    if (item.cmd == ebca_pkg::CMD_START) begin
      edge_previous_next     = stable_level_next;
      code_value_next        = start_val[CODE_WIDTH-1:0];
      channel_latch_next     = item.dac_channel;
      encoder_reference_next = item.encoder_count;
      coarse_flag_next       = 1'b1;
      swallow_flag_next      = 1'b0;
      active_flag_next       = 1'b1;
      written                = 1'b1;
    end else if (active_flag) begin
      // at most one detent per poll
      if (step_up) begin
        encoder_reference_next = encoder_reference + 16'(det);
        code_value_next        = up_val[CODE_WIDTH-1:0];
        written                = 1'b1;
      end else if (step_dn) begin
        encoder_reference_next = encoder_reference - 16'(det);
        code_value_next        = dn_val[CODE_WIDTH-1:0];
        written                = 1'b1;
      end

      if (fire) begin
        confirm          = 1'b1;
        active_flag_next = 1'b0;
      end else begin
        // click toggles the step, then swallowed until release
        if (!swallow_flag) begin
          press              = stable_level_next && !edge_previous;
          edge_previous_next = stable_level_next;
          if (press) begin
            coarse_flag_next = !coarse_flag;
            swallow_mid      = 1'b1;
          end
        end
        swallow_flag_next = swallow_mid;
        if (swallow_mid && !stable_level_next) begin
          swallow_flag_next  = 1'b0;
          edge_previous_next = stable_level_next;
        end
      end
    end
  end

  assign code_wide          = {16'b0, code_value_next};
  assign res.dac_code       = code_wide[15:0];
  assign res.out_channel    = channel_latch_next;
  assign res.code_written   = written;
  assign res.coarse_mode    = coarse_flag_next;
  assign res.confirmed      = confirm;
  assign res.session_active = active_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_value        <= '0;
      channel_latch     <= '0;
      encoder_reference <= '0;
      coarse_flag       <= 1'b1;
      swallow_flag      <= 1'b0;
      active_flag       <= 1'b0;
      stable_level      <= 1'b0;
      candidate_level   <= 1'b0;
      candidate_since   <= '0;
      edge_previous     <= 1'b0;
      hold_seen         <= 1'b0;
      hold_start        <= '0;
      hold_fired        <= 1'b0;
    end else if (en) begin
      code_value        <= code_value_next;
      channel_latch     <= channel_latch_next;
      encoder_reference <= encoder_reference_next;
      coarse_flag       <= coarse_flag_next;
      swallow_flag      <= swallow_flag_next;
      active_flag       <= active_flag_next;
      stable_level      <= stable_level_next;
      candidate_level   <= candidate_level_next;
      candidate_since   <= candidate_since_next;
      edge_previous     <= edge_previous_next;
      hold_seen         <= hold_seen_next;
      hold_start        <= hold_start_next;
      hold_fired        <= hold_fired_next;
    end
  end

endmodule

>>> hdl/encoder_button_code_adjuster.sv
// ----------------------------------------------------------------------------
// encoder_button_code_adjuster
// adjusts a dac code from encoder detents and a debounced push button
// ----------------------------------------------------------------------------
// a request passes through the input register, then its result is registered
// in the result register, from which it is taken on the result channel
// throughput: one request per cycle while results are taken, set by the single-pass state update
// intake stalls only while both registers are full and the result is not taken
// reset (rst, synchronous): both stages empty, registers at defaults,
// session idle with coarse step selected
module encoder_button_code_adjuster #(
  parameter int CODE_WIDTH = ebca_pkg::CODE_WIDTH_DEFAULT,
  parameter int TIME_WIDTH = ebca_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // apb configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ebca_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [ebca_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [ebca_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  // request and result channels
  ebca_req_if.sink                             item,
  ebca_rsp_if.source                           result
);

  ebca_pkg::ebca_cfg_t    cfg;
  ebca_pkg::ebca_item_t   req;        // request register payload
  logic                   req_valid;
  ebca_pkg::ebca_result_t step_res;   // next result from the update logic
  ebca_pkg::ebca_result_t rsp;        // result register payload
  logic                   rsp_valid;
  logic                   advance;    // result register can take a new result
  logic                   step_en;    // request register commits this cycle

  ebca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ebca_step #(
    .CODE_WIDTH (CODE_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (step_en),
    .item (req),
    .cfg  (cfg),
    .res  (step_res)
  );

  // pipeline flow control: the request stage moves whenever the result stage
  // is empty or being drained this cycle
  assign advance    = !rsp_valid || result.ready;
  assign step_en    = req_valid && advance;
  assign item.ready = !req_valid || advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item.ready) begin
      req_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      req.cmd           <= item.cmd;
      req.start_value   <= item.start_value;
      req.dac_channel   <= item.dac_channel;
      req.button_level  <= item.button_level;
      req.encoder_count <= item.encoder_count;
      req.now_ms        <= item.now_ms;
    end
  end

  // result register, state commits in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      rsp <= step_res;
    end
  end

  assign result.valid          = rsp_valid;
  assign result.dac_code       = rsp.dac_code;
  assign result.out_channel    = rsp.out_channel;
  assign result.code_written   = rsp.code_written;
  assign result.coarse_mode    = rsp.coarse_mode;
  assign result.confirmed      = rsp.confirmed;
  assign result.session_active = rsp.session_active;

  // a confirmed code always closes the session
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.confirmed |-> !rsp.session_active)
    else $error("confirmed result with session still active");

  // an idle poll never writes the code
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.session_active && !rsp.confirmed |-> !rsp.code_written)
    else $error("code written while no session was active");

  // every committed request shows up in the result register
  assert property (@(posedge clk) disable iff (rst)
    step_en |=> rsp_valid)
    else $error("committed request produced no result");

  // reset empties both stages
  assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_valid)
    else $error("pipeline not empty after reset");

endmodule
